// File: hw/rtl/fvbc_pkg.sv
// ----------------------------------------------------------------------------
// fvbc_pkg
// shared types and codes for the fog volume box classifier
// ----------------------------------------------------------------------------
package fvbc_pkg;

   localparam int COORD_W     = 32;
   localparam int SLOT_W      = 4;
   localparam int COUNT_W     = 5;
   localparam int FOG_MAX_DEF = 16;
   localparam int SLOT_LIMIT  = 16;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vec_type;

   typedef struct packed {
      vec_type hi;
      vec_type lo;
   } box_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_VERTEX = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FOG_COUNT = 1'b0,
      CSR_WORLD     = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

endpackage

// File: hw/rtl/fvbc_table.sv
// ----------------------------------------------------------------------------
// fvbc_table
// fog box memory with registered read and inclusive overlap test
// ----------------------------------------------------------------------------
module fvbc_table #(
   parameter int FOG_MAX = fvbc_pkg::FOG_MAX_DEF,
   parameter int AW      = $clog2(FOG_MAX)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  fvbc_pkg::box_type wr_box,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   input  fvbc_pkg::box_type run_box,
   output logic              hit
);
   import fvbc_pkg::*;

   box_type mem [FOG_MAX];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_box;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // polygon max >= fog min and polygon min <= fog max on every axis
   always_comb begin
      hit = (run_box.hi.x >= rd_data_ff.lo.x) && (run_box.lo.x <= rd_data_ff.hi.x) &&
            (run_box.hi.y >= rd_data_ff.lo.y) && (run_box.lo.y <= rd_data_ff.hi.y) &&
            (run_box.hi.z >= rd_data_ff.lo.z) && (run_box.lo.z <= rd_data_ff.hi.z);
   end

endmodule

// File: hw/rtl/fog_volume_box_classifier_core.sv
// ----------------------------------------------------------------------------
// fog_volume_box_classifier_core
// polygon bounding box against a table of fog volume boxes
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load item writes one
// fog box (min corner on coord, max corner on far) into the table; slots at or
// beyond FOG_MAX are dropped. A vertex item widens the running polygon box and
// gives no result unless it is the last vertex.
// On the last vertex, with world_present set, the block walks slots
// 1 .. limit-1 (limit is the smaller of fog_count, FOG_MAX and 16) through
// the table memory, one slot read per cycle, with the compare in the cycle
// after the read. The first hit ends the walk, and rsp_valid strobes
// fog_index for one cycle as busy drops. Loads and plain vertices do not
// raise busy.
// The csr channel is always ready; writes are expected only while idle.
// Reset clears the polygon state and sets fog_count and world_present to 1;
// the table is not cleared. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module fog_volume_box_classifier_core #(
   parameter int FOG_MAX = fvbc_pkg::FOG_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  fvbc_pkg::slot_type    req_slot,
   input  fvbc_pkg::coord_type   req_coord_x,
   input  fvbc_pkg::coord_type   req_coord_y,
   input  fvbc_pkg::coord_type   req_coord_z,
   input  fvbc_pkg::coord_type   req_far_x,
   input  fvbc_pkg::coord_type   req_far_y,
   input  fvbc_pkg::coord_type   req_far_z,
   input  logic                  req_last_vertex,
   output logic                  rsp_valid,
   output fvbc_pkg::slot_type    rsp_fog_index,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  fvbc_pkg::count_type   csr_data
);
   import fvbc_pkg::*;

   localparam int AW = $clog2(FOG_MAX);
   localparam logic [8:0] FOG_MAX_W    = 9'(FOG_MAX);
   localparam logic [8:0] SLOT_LIMIT_W = 9'(SLOT_LIMIT);

   state_type state_ff, state_in;
   count_type fog_count_ff, fog_count_in;
   logic      world_ff, world_in;
   logic      open_ff, open_in;
   box_type   run_ff, run_in;
   count_type issue_ff, issue_in;
   logic      cmp_valid_ff, cmp_valid_in;
   slot_type  cmp_slot_ff, cmp_slot_in;
   logic      rsp_valid_ff, rsp_valid_in;
   slot_type  rsp_index_ff, rsp_index_in;

   logic      accept, load_acc, vert_acc, last_acc;
   logic      wr_en, issue_en, hit, done_hit, done_miss;
   logic [8:0] lim_wide;
   count_type limit;
   vec_type   v;
   box_type   wr_box;
   csr_index_type csr_sel;

   assign accept   = start && !busy;
   assign load_acc = accept && (op_type'(req_operation) == OP_LOAD);
   assign vert_acc = accept && (op_type'(req_operation) == OP_VERTEX);
   assign last_acc = vert_acc && req_last_vertex;
   assign wr_en    = load_acc && (9'(req_slot) < FOG_MAX_W);
   assign csr_ready = 1'b1;
   assign csr_sel  = csr_index_type'(csr_index);

   assign v      = '{z: req_coord_z, y: req_coord_y, x: req_coord_x};
   assign wr_box = '{hi: '{z: req_far_z, y: req_far_y, x: req_far_x}, lo: v};

   // search limit: smaller of fog_count, table depth and loadable slots
   always_comb begin
      lim_wide = 9'(fog_count_ff);
      if (lim_wide > FOG_MAX_W) begin
         lim_wide = FOG_MAX_W;
      end
      if (lim_wide > SLOT_LIMIT_W) begin
         lim_wide = SLOT_LIMIT_W;
      end
      limit = COUNT_W'(lim_wide);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (last_acc) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (done_hit || done_miss) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy      = 1'b0;
      issue_en  = 1'b0;
      done_hit  = 1'b0;
      done_miss = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SEARCH: begin
            busy      = 1'b1;
            issue_en  = world_ff && (issue_ff < limit);
            done_hit  = cmp_valid_ff && hit;
            done_miss = !issue_en && !cmp_valid_ff;
         end
         default: busy = 1'b0;
      endcase
   end

   // running box and walk counters
   always_comb begin
      open_in      = open_ff;
      run_in       = run_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_slot_in  = cmp_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      if (vert_acc) begin
         if (!open_ff) begin
            run_in = '{hi: v, lo: v};
         end else begin
            if (v.x < run_ff.lo.x) run_in.lo.x = v.x;
            if (v.y < run_ff.lo.y) run_in.lo.y = v.y;
            if (v.z < run_ff.lo.z) run_in.lo.z = v.z;
            if (v.x > run_ff.hi.x) run_in.hi.x = v.x;
            if (v.y > run_ff.hi.y) run_in.hi.y = v.y;
            if (v.z > run_ff.hi.z) run_in.hi.z = v.z;
         end
         open_in = !req_last_vertex;
      end
      if (last_acc) begin
         issue_in = COUNT_W'(1);
      end
      if (issue_en) begin
         issue_in     = issue_ff + COUNT_W'(1);
         cmp_valid_in = 1'b1;
         cmp_slot_in  = SLOT_W'(issue_ff);
      end
      if (done_hit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = cmp_slot_ff;
         cmp_valid_in = 1'b0;
      end else if (done_miss) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = '0;
      end
   end

   // configuration
   always_comb begin
      fog_count_in = fog_count_ff;
      world_in     = world_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_FOG_COUNT: fog_count_in = csr_data;
            CSR_WORLD:     world_in     = csr_data[0];
            default:       world_in     = world_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fog_count_ff <= COUNT_W'(1);
         world_ff     <= 1'b1;
         open_ff      <= 1'b0;
         run_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fog_count_ff <= fog_count_in;
         world_ff     <= world_in;
         open_ff      <= open_in;
         run_ff       <= run_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff     <= issue_in;
      cmp_slot_ff  <= cmp_slot_in;
      rsp_index_ff <= rsp_index_in;
   end

   fvbc_table #(
      .FOG_MAX (FOG_MAX),
      .AW      (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_box  (wr_box),
      .rd_en   (issue_en),
      .rd_addr (AW'(issue_ff)),
      .run_box (run_ff),
      .hit     (hit)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fog_index = rsp_index_ff;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fog volume box classifier core
// ----------------------------------------------------------------------------
// Loads fog boxes and streams polygon vertices through the start/busy port.
// A predictor keeps its own fog table, running polygon box and register copy,
// and works out the first overlapping slot for every last vertex. Each result
// strobe is checked in order against that. A directed opening covers extreme
// coordinates, single point polygons, loads inside an open polygon and
// boundary overlaps. Random phases then retune fog_count and world_present
// while idle and send bursty polygons with stray loads mixed in.
// ----------------------------------------------------------------------------
module tb;
   import fvbc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 100;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      op_type   op;
      slot_type slot;
      vec_type  near_c;
      vec_type  far_c;
      logic     last;
   } fog_item_type;

   class fog_overlap_tracker;
      coord_type   fog_lo [SLOT_LIMIT][3];
      coord_type   fog_hi [SLOT_LIMIT][3];
      coord_type   poly_lo [3];
      coord_type   poly_hi [3];
      logic        poly_open;
      count_type   fog_count;
      logic        world_present;
      slot_type    expected_fog_index [$];
      int          fail_count;
      int          results_checked;
      int          hits_seen;

      function new();
         poly_open     = 1'b0;
         fog_count     = count_type'(1);
         world_present = 1'b1;
         fail_count    = 0;
         results_checked = 0;
         hits_seen     = 0;
         for (int a = 0; a < 3; a++) begin
            poly_lo[a] = '0;
            poly_hi[a] = '0;
         end
      endfunction

      function void set_reg(csr_index_type idx, count_type data);
         if (idx == CSR_FOG_COUNT) begin
            fog_count = data;
         end else begin
            world_present = data[0];
         end
      endfunction

      function slot_type first_overlapping_slot();
         int  lim;
         logic hit;
         lim = int'(fog_count);
         if (lim > FOG_MAX_DEF) lim = FOG_MAX_DEF;
         if (lim > SLOT_LIMIT) lim = SLOT_LIMIT;
         if (!world_present) return '0;
         for (int s = 1; s < lim; s++) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++) begin
               if ($signed(poly_hi[a]) < $signed(fog_lo[s][a])) hit = 1'b0;
               if ($signed(poly_lo[a]) > $signed(fog_hi[s][a])) hit = 1'b0;
            end
            if (hit) return slot_type'(s);
         end
         return '0;
      endfunction

      function void take_item(fog_item_type it);
         coord_type v [3];
         coord_type f [3];
         v = '{it.near_c.x, it.near_c.y, it.near_c.z};
         f = '{it.far_c.x, it.far_c.y, it.far_c.z};
         if (it.op == OP_LOAD) begin
            for (int a = 0; a < 3; a++) begin
               fog_lo[it.slot][a] = v[a];
               fog_hi[it.slot][a] = f[a];
            end
            return;
         end
         for (int a = 0; a < 3; a++) begin
            if (!poly_open) begin
               poly_lo[a] = v[a];
               poly_hi[a] = v[a];
            end else begin
               if ($signed(v[a]) < $signed(poly_lo[a])) poly_lo[a] = v[a];
               if ($signed(v[a]) > $signed(poly_hi[a])) poly_hi[a] = v[a];
            end
         end
         poly_open = 1'b1;
         if (it.last) begin
            poly_open = 1'b0;
            expected_fog_index.push_back(first_overlapping_slot());
         end
      endfunction

      function void check_fog_index(slot_type got);
         slot_type want;
         if (expected_fog_index.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: fog_index %0d with nothing pending", got);
            return;
         end
         want = expected_fog_index.pop_front();
         results_checked++;
         if (want != 0) hits_seen++;
         if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("fog_index mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return expected_fog_index.size();
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   logic      req_operation;
   slot_type  req_slot;
   coord_type req_coord_x;
   coord_type req_coord_y;
   coord_type req_coord_z;
   coord_type req_far_x;
   coord_type req_far_y;
   coord_type req_far_z;
   logic      req_last_vertex;
   logic      rsp_valid;
   slot_type  rsp_fog_index;
   logic      csr_valid;
   logic      csr_ready;
   logic      csr_index;
   count_type csr_data;

   fog_overlap_tracker fog_sb = new();

   int cycle_count  = 0;
   int items_sent   = 0;
   int burst_left   = 0;

   fog_volume_box_classifier_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_slot        (req_slot),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_far_x       (req_far_x),
      .req_far_y       (req_far_y),
      .req_far_z       (req_far_z),
      .req_last_vertex (req_last_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_fog_index   (rsp_fog_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) fog_sb.check_fog_index(rsp_fog_index);
   end

   // mostly a small area so boxes overlap often, with extremes and full range
   function automatic coord_type rand_coord();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 32'sh8000_0000;
      if (pick == 1) return 32'sh7fff_ffff;
      if (pick < 4) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 2400)) - 1200);
   endfunction

   function automatic fog_item_type make_vertex(coord_type x, coord_type y, coord_type z,
                                                logic last);
      fog_item_type it;
      it.op     = OP_VERTEX;
      it.slot   = slot_type'($urandom);
      it.near_c = '{z: z, y: y, x: x};
      it.far_c  = vec_type'({$urandom, $urandom, $urandom});
      it.last   = last;
      return it;
   endfunction

   function automatic fog_item_type make_load(slot_type s, vec_type lo, vec_type hi);
      fog_item_type it;
      it.op     = OP_LOAD;
      it.slot   = s;
      it.near_c = lo;
      it.far_c  = hi;
      it.last   = logic'($urandom);
      return it;
   endfunction

   function automatic fog_item_type rand_load(slot_type s);
      coord_type   lo [3];
      coord_type   hi [3];
      int unsigned mode;
      int          c;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (mode == 0) begin
            lo[a] = coord_type'($urandom);
            hi[a] = coord_type'($urandom);
         end else if (mode == 1) begin
            lo[a] = 32'sh8000_0000;
            hi[a] = 32'sh7fff_ffff;
         end else begin
            c     = int'($urandom_range(0, 2000)) - 1000;
            lo[a] = coord_type'(c - int'($urandom_range(0, 800)));
            hi[a] = coord_type'(c + int'($urandom_range(0, 800)));
         end
      end
      return make_load(s, '{z: lo[2], y: lo[1], x: lo[0]}, '{z: hi[2], y: hi[1], x: hi[0]});
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(fog_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      start           <= 1'b1;
      req_operation   <= it.op;
      req_slot        <= it.slot;
      req_coord_x     <= it.near_c.x;
      req_coord_y     <= it.near_c.y;
      req_coord_z     <= it.near_c.z;
      req_far_x       <= it.far_c.x;
      req_far_y       <= it.far_c.y;
      req_far_z       <= it.far_c.z;
      req_last_vertex <= it.last;
      do @(posedge clock); while (busy);
      fog_sb.take_item(it);
      items_sent++;
      @(negedge clock);
   endtask

   // waits for the block to drain, then writes both registers back to back
   task automatic write_regs(count_type fog_count, logic world);
      start <= 1'b0;
      while (fog_sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_FOG_COUNT;
      csr_data  <= fog_count;
      do @(posedge clock); while (!csr_ready);
      fog_sb.set_reg(CSR_FOG_COUNT, fog_count);
      @(negedge clock);
      csr_index <= CSR_WORLD;
      csr_data  <= count_type'(world);
      do @(posedge clock); while (!csr_ready);
      fog_sb.set_reg(CSR_WORLD, count_type'(world));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      coord_type  cmin;
      coord_type  cmax;
      coord_type  base;
      count_type  cnt;
      logic       world;
      int         phase_items;
      int unsigned nverts;

      cmin = 32'sh8000_0000;
      cmax = 32'sh7fff_ffff;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_LOAD;
      req_slot        = '0;
      req_coord_x     = '0;
      req_coord_y     = '0;
      req_coord_z     = '0;
      req_far_x       = '0;
      req_far_y       = '0;
      req_far_z       = '0;
      req_last_vertex = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_FOG_COUNT;
      csr_data        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config searches nothing, so vertices may come before any load
      send_item(make_vertex(cmax, cmax, cmax, 1'b0));
      send_item(make_vertex(cmin, cmin, cmin, 1'b1));
      send_item(make_vertex(32'sh0, -32'sh1, 32'sh1234_5678, 1'b1));

      // fill the whole table before any search can reach it
      send_item(make_load(slot_type'(0), '{z: cmin, y: cmin, x: cmin},
                          '{z: cmax, y: cmax, x: cmax}));
      for (int s = 1; s < SLOT_LIMIT - 1; s++) begin
         base = coord_type'(s * 1000);
         send_item(make_load(slot_type'(s), '{z: base, y: base, x: base},
                             '{z: base + 500, y: base + 500, x: base + 500}));
      end
      send_item(make_load(slot_type'(SLOT_LIMIT - 1), '{z: cmin, y: cmin, x: cmin},
                          '{z: cmax, y: cmax, x: cmax}));

      write_regs(count_type'(16), 1'b1);
      send_item(make_vertex(32'sd3000, 32'sd3000, 32'sd3000, 1'b1));
      // load inside an open polygon, polygon meets slot 2's max corner on x and z but not on y
      send_item(make_vertex(32'sd2500, 32'sd2550, 32'sd2600, 1'b0));
      send_item(make_load(slot_type'(0), '{z: 32'sd7, y: 32'sd7, x: 32'sd7},
                          '{z: 32'sd9, y: 32'sd9, x: 32'sd9}));
      send_item(make_vertex(32'sd2600, 32'sd2600, 32'sd2500, 1'b1));
      send_item(make_vertex(-32'sd5, -32'sd5, -32'sd5, 1'b1));
      send_item(make_vertex(cmax, cmin, cmax, 1'b1));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin cnt = count_type'(16); world = 1'b1; end
            1: begin cnt = count_type'(0);  world = 1'b1; end
            2: begin cnt = count_type'(2);  world = 1'b1; end
            3: begin cnt = count_type'(16); world = 1'b0; end
            4: begin cnt = count_type'(1);  world = 1'b1; end
            5: begin cnt = count_type'(15); world = 1'b1; end
            default: begin
               cnt   = count_type'($urandom_range(0, 16));
               world = ($urandom_range(0, 4) != 0);
            end
         endcase
         write_regs(cnt, world);
         phase_items = 0;
         repeat ($urandom_range(0, 8)) begin
            send_item(rand_load(slot_type'($urandom)));
            phase_items++;
         end
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(rand_load(slot_type'($urandom)));
               phase_items++;
            end else begin
               nverts = $urandom_range(1, 4);
               for (int v = 0; v < nverts; v++) begin
                  if (v > 0 && $urandom_range(0, 9) == 0) begin
                     send_item(rand_load(slot_type'($urandom)));
                     phase_items++;
                  end
                  send_item(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                        v == nverts - 1));
                  phase_items++;
               end
            end
         end
      end

      start <= 1'b0;
      while (fog_sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items over %0d register settings", items_sent, PHASE_COUNT + 2);
      $display("checked %0d polygon results, %0d of them fog hits",
               fog_sb.results_checked, fog_sb.hits_seen);
      if (fog_sb.fail_count == 0 && fog_sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures, %0d results still pending",
                  fog_sb.fail_count, fog_sb.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
